[src/lfo_pkg.sv]
// ----------------------------------------------------------------------------
// lfo_pkg
// Shared types, constants and the quarter-wave sine table of the LFO.
// ----------------------------------------------------------------------------
package lfo_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int STEP_W      = 16;
    localparam int FREQ_W      = 16;
    localparam int WAVE_W      = 3;
    localparam int PHASE_W     = 32;
    localparam int LFSR_W      = 32;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [FREQ_W-1:0]          FREQ_RESET  = 16'd256;
    localparam logic signed [SAMPLE_W-1:0] FULL_SCALE  = 16'sd32767;
    localparam logic [LFSR_W-1:0]          LFSR_MASK   = 32'h8020_0003;
    localparam logic [LFSR_W-1:0]          LFSR_SEED   = 32'h0000_0001;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WAVEFORM  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_FREQUENCY = 1'b1;

    // waveform codes
    typedef enum logic [WAVE_W-1:0] {
        WAVE_SQUARE  = 3'd0,
        WAVE_SINE    = 3'd1,
        WAVE_SAW     = 3'd2,
        WAVE_NOISE   = 3'd3,
        WAVE_RSQUARE = 3'd4
    } wave_t;

    // random levels handed from the random source to the waveform shaper
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] noise;
        logic signed [SAMPLE_W-1:0] held;
    } rand_levels_t;

    // quarter-wave sine table
    localparam int SINE_TABLE_BITS = 8;
    localparam int SINE_ROM_DEPTH  = (1 << SINE_TABLE_BITS) + 1;
    localparam int SINE_IDX_W      = SINE_TABLE_BITS + 1;
    localparam int ROM_W           = 15;

    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [0:6] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef logic [ROM_W-1:0] sine_rom_t [0:SINE_ROM_DEPTH-1];

    // Q30 Taylor series of sin, scaled to full scale and rounded
    function automatic logic [ROM_W-1:0] sine_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] scaled;
        x    = (Q30_HALF_PI * 64'(idx)) >> SINE_TABLE_BITS;
        term = x;
        sum  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[k-1];
            if ((k % 2) == 1)
            begin
                sum = sum - term;
            end
            else
            begin
                sum = sum + term;
            end
        end
        scaled = sum * 64'd32767 + (64'd1 << 29);
        return scaled[30 +: ROM_W];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int i = 0; i < SINE_ROM_DEPTH; i++)
        begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

[src/lfo_waveform_generator.sv]
// ----------------------------------------------------------------------------
// lfo_waveform_generator
// Low-frequency oscillator: one signed Q1.15 sample per time-step word.
// An accepted input word is held in the input stage, its sample in the result stage.
// Throughput: one word per cycle while the output is not stalled; the phase
// update (one 16x16 multiply and a 32-bit add) and the sine table read sit
// between two register stages. Reset: phase and held level clear, LFSR seeds
// to one, waveform square, frequency 1 Hz; both pipeline stages come up empty.
// ----------------------------------------------------------------------------
module lfo_waveform_generator
    import lfo_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [STEP_W-1:0]     s_tdata,   // [15:0] time_step
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [SAMPLE_W-1:0]   m_tdata    // [15:0] sample (signed)
);

    // configuration registers
    logic [WAVE_W-1:0] waveform_reg;
    logic [FREQ_W-1:0] frequency_reg;

    // input stage and result stage
    logic              in_valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic               out_free;
    logic               advance;
    logic [PHASE_W-1:0] phase;
    logic               first_half;
    rand_levels_t       levels;
    logic signed [SAMPLE_W-1:0] sample_next;

    // The result stage frees up when it is empty or being drained; the input
    // stage then hands its word on, so a new word is taken every cycle while
    // the downstream side keeps up.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Sample is formed from the phase held before this word's increment.
    assign first_half = !phase[PHASE_W-1];

    // Write configuration; the user must do so only while the pipeline is empty, which the block does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg  <= WAVE_SQUARE;
            frequency_reg <= FREQ_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_WAVEFORM:  waveform_reg  <= cfg_wdata[WAVE_W-1:0];
                REG_FREQUENCY: frequency_reg <= cfg_wdata[FREQ_W-1:0];
                default:       ;
            endcase
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Stage payloads: hold while stalled.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            step_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= sample_next;
        end
    end

    // Phase accumulator: advance once per word leaving the input stage.
    lfo_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .time_step (step_reg),
        .frequency (frequency_reg),
        .phase     (phase)
    );

    // Random source for noise and random square.
    lfo_rand u_rand (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .waveform   (waveform_reg),
        .first_half (first_half),
        .levels     (levels)
    );

    // Waveform shaper.
    lfo_shape u_shape (
        .waveform (waveform_reg),
        .phase    (phase),
        .levels   (levels),
        .sample   (sample_next)
    );

endmodule

[src/lfo_accum.sv]
// ----------------------------------------------------------------------------
// lfo_accum
// Phase accumulator: advance the phase by time step times frequency.
// ----------------------------------------------------------------------------
module lfo_accum
    import lfo_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [STEP_W-1:0]  time_step,
    input  logic [FREQ_W-1:0]  frequency,
    output logic [PHASE_W-1:0] phase
);

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [PHASE_W-1:0] incr;

    assign incr       = PHASE_W'(time_step) * PHASE_W'(frequency);
    assign phase_next = phase_reg + incr;
    assign phase      = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

[src/lfo_rand.sv]
// ----------------------------------------------------------------------------
// lfo_rand
// Random source: Galois LFSR, noise level and random-square held level.
// ----------------------------------------------------------------------------
module lfo_rand
    import lfo_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic [WAVE_W-1:0] waveform,
    input  logic              first_half,
    output rand_levels_t      levels
);

    logic [LFSR_W-1:0]          lfsr_reg;
    logic [LFSR_W-1:0]          lfsr_next;
    logic signed [SAMPLE_W-1:0] held_reg;
    logic signed [SAMPLE_W-1:0] held_next;
    logic                       second_half_reg;
    logic signed [SAMPLE_W-1:0] draw;
    logic                       is_noise;
    logic                       is_rsquare;
    logic                       new_draw;

    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : '0);

    // saturate the one code that has no positive twin
    always_comb
    begin
        draw = signed'(lfsr_next[SAMPLE_W-1:0]);
        if (draw == -FULL_SCALE - 16'sd1)
        begin
            draw = -FULL_SCALE;
        end
    end

    assign is_noise   = (waveform == WAVE_NOISE);
    assign is_rsquare = (waveform == WAVE_RSQUARE);
    assign new_draw   = is_rsquare && first_half && second_half_reg;

    always_comb
    begin
        held_next = held_reg;
        if (first_half)
        begin
            if (second_half_reg)
            begin
                held_next = draw;
            end
        end
        else if (!second_half_reg)
        begin
            held_next = -held_reg;
        end
    end

    assign levels.noise = draw;
    assign levels.held  = held_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg        <= LFSR_SEED;
            held_reg        <= '0;
            second_half_reg <= 1'b1;
        end
        else if (advance)
        begin
            if (is_noise || new_draw)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (is_rsquare)
            begin
                held_reg        <= held_next;
                second_half_reg <= !first_half;
            end
        end
    end

endmodule

[src/lfo_shape.sv]
// ----------------------------------------------------------------------------
// lfo_shape
// Waveform shaper: map the phase and random levels to one Q1.15 sample.
// ----------------------------------------------------------------------------
module lfo_shape
    import lfo_pkg::*;
(
    input  logic [WAVE_W-1:0]          waveform,
    input  logic [PHASE_W-1:0]         phase,
    input  rand_levels_t               levels,
    output logic signed [SAMPLE_W-1:0] sample
);

    logic [1:0]                 quad;
    logic [SINE_IDX_W-1:0]      k_idx;
    logic [SINE_IDX_W-1:0]      rom_idx;
    logic [ROM_W-1:0]           rom_val;
    logic signed [SAMPLE_W-1:0] sine_val;
    logic [48:0]                saw_prod;
    logic signed [SAMPLE_W:0]   saw_wide;
    logic signed [SAMPLE_W-1:0] square_val;

    // sine: quadrant from the top two bits, index from the next ones
    assign quad    = phase[PHASE_W-1 -: 2];
    assign k_idx   = {1'b0, phase[PHASE_W-3 -: SINE_TABLE_BITS]};
    assign rom_idx = quad[0] ? (SINE_IDX_W'(1 << SINE_TABLE_BITS) - k_idx) : k_idx;
    assign rom_val = SINE_ROM[rom_idx];
    assign sine_val = quad[1] ? -signed'({1'b0, rom_val}) : signed'({1'b0, rom_val});

    // saw: phase * 65534 as phase * 2^16 - phase * 2
    assign saw_prod = {1'b0, phase, 16'b0} - {16'b0, phase, 1'b0};
    assign saw_wide = signed'({1'b0, saw_prod[47:32]}) - 17'sd32767;

    assign square_val = phase[PHASE_W-1] ? FULL_SCALE : -FULL_SCALE;

    always_comb
    begin
        unique case (waveform)
            WAVE_SQUARE:  sample = square_val;
            WAVE_SINE:    sample = sine_val;
            WAVE_SAW:     sample = saw_wide[SAMPLE_W-1:0];
            WAVE_NOISE:   sample = levels.noise;
            WAVE_RSQUARE: sample = levels.held;
            default:      sample = '0;
        endcase
    end

endmodule

[src/lfo_checker.sv]
// ----------------------------------------------------------------------------
// lfo_checker
// Port-level checks of the LFO stream behavior, bound to the top level.
// ----------------------------------------------------------------------------
module lfo_checker
    import lfo_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [SAMPLE_W-1:0]   m_tdata
);

    // a stalled sample holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled sample changed");

    // every accepted word is followed by a valid output once it has passed the input and result stages
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##2 m_tvalid)
        else $error("sample missing after accepted word");

    // with a word just taken and the output stalled, the pipeline is full
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && $past(s_tvalid && s_tready) && m_tvalid && !m_tready
        |-> !s_tready)
        else $error("word taken with full pipeline");

endmodule

bind lfo_waveform_generator lfo_checker u_checker (.*);

[tb/sv/lfo_waveform_generator_tb.sv]
// ----------------------------------------------------------------------------
// lfo_waveform_generator_tb
// Self-checking bench for the LFO. A predictor (phase accumulator,
// sine table, LFSR and random-square state) runs beside the block. Every
// sample word on the output stream is matched against the oldest predicted
// sample. The stimulus starts with a directed table, then looks a short way
// ahead for the saturated noise code, then runs random blocks under four
// idling modes.
// ----------------------------------------------------------------------------
module lfo_waveform_generator_tb
    import lfo_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // predictor constants
    localparam int          SINE_BITS    = 8;
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          PEAK         = 32767;
    localparam logic [31:0] LFSR_POLY    = 32'h8020_0003;
    localparam int          HUNT_LIMIT   = 40;
    localparam int          BLOCKS       = 16;
    localparam int          BLOCK_WORDS  = 25;

    // idling modes: none, sender idle, receiver stall, both
    localparam int SEND_IDLE [4] = '{0, 76, 0, 37};
    localparam int RECV_STALL [4] = '{0, 0, 76, 37};

    typedef enum logic {ROW_CFG, ROW_STEP} row_kind_t;

    // CFG rows: word = waveform register, freq = frequency register
    // STEP rows: word = time step, typed/sample = expectation read off directly
    typedef struct packed {
        row_kind_t          kind;
        logic [15:0]        word;
        logic [15:0]        freq;
        logic               typed;
        logic signed [15:0] sample;
    } plan_row_t;

    localparam int PLAN_LEN = 29;

    plan_row_t directed_plan [PLAN_LEN] = '{
        // after reset: square, 1 Hz, phase zero
        '{ROW_STEP, 16'h0000, 16'h0000, 1'b1, -16'sd32767},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b1, -16'sd32767},
        // largest frequency
        '{ROW_CFG,  16'(WAVE_SQUARE), 16'hFFFF, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b1, -16'sd32767},
        '{ROW_STEP, 16'h8000, 16'h0000, 1'b0, 16'sd0},
        // frequency zero: phase holds
        '{ROW_CFG,  16'(WAVE_SQUARE), 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h1234, 16'h0000, 1'b0, 16'sd0},
        // sine through the third and fourth quadrants, the phase advancing by an eighth of its range per word
        '{ROW_CFG,  16'(WAVE_SINE), 16'h8000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_CFG,  16'(WAVE_SAW), 16'h8000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h4000, 16'h0000, 1'b0, 16'sd0},
        '{ROW_CFG,  16'(WAVE_NOISE), 16'h0001, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hAAAA, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h5555, 16'h0000, 1'b0, 16'sd0},
        '{ROW_CFG,  16'(WAVE_RSQUARE), 16'hFFFF, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b0, 16'sd0},
        // undefined waveform codes give silence; upper word bits are don't-care
        '{ROW_CFG,  16'hFFFF, 16'h0100, 1'b0, 16'sd0},
        '{ROW_STEP, 16'hFFFF, 16'h0000, 1'b1, 16'sd0},
        '{ROW_STEP, 16'h0000, 16'h0000, 1'b1, 16'sd0},
        '{ROW_CFG,  16'h0005, 16'hFFFF, 1'b0, 16'sd0},
        '{ROW_STEP, 16'h0001, 16'h0000, 1'b1, 16'sd0}
    };

    // DUT inputs, all known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic [STEP_W-1:0]     s_tdata   = '0;
    logic                  m_tready  = 1'b0;
    logic                  s_tready;
    logic                  m_tvalid;
    logic [SAMPLE_W-1:0]   m_tdata;    // [15:0] sample (signed)

    // travels with the input word: a typed-in expectation, if any
    logic                  step_typed        = 1'b0;
    logic [SAMPLE_W-1:0]   step_typed_sample = '0;

    // oscillator state mirrored by the predictor
    logic [31:0]           osc_phase      = '0;
    logic signed [15:0]    osc_level      = '0;
    logic                  osc_upper_half = 1'b1;
    logic [31:0]           osc_lfsr       = 32'd1;
    logic [WAVE_W-1:0]     osc_wave       = 3'(WAVE_SQUARE);
    logic [FREQ_W-1:0]     osc_freq       = 16'd256;

    logic [SAMPLE_W-1:0]   expected_samples [$];
    logic [SAMPLE_W-1:0]   want_sample;
    logic [SAMPLE_W-1:0]   new_sample;

    int                    mismatch_count = 0;
    int                    send_idle_pct  = 0;
    int                    stall_pct      = 0;

    lfo_waveform_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // [15:0] time_step
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)      // [15:0] sample (signed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // quarter-wave table entry, Q30 Taylor series rounded to full scale
    function automatic int quarter_sine(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        x    = (HALF_PI_Q30 * 64'(idx)) >> SINE_BITS;
        term = x;
        acc  = x;
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / (64'(2 * k) * 64'(2 * k + 1));
            if ((k % 2) == 1)
            begin
                acc = acc - term;
            end
            else
            begin
                acc = acc + term;
            end
        end
        return int'((acc * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    // quadrant from the top two phase bits, truncated table index below them
    function automatic int sine_at(input logic [31:0] ph);
        logic [31:0] idx;
        int          mag;
        idx = (ph >> (30 - SINE_BITS)) & ((32'd1 << SINE_BITS) - 32'd1);
        if (ph[30])
        begin
            mag = quarter_sine((1 << SINE_BITS) - int'(idx));
        end
        else
        begin
            mag = quarter_sine(int'(idx));
        end
        return ph[31] ? -mag : mag;
    endfunction

    // advance the Galois LFSR once; low half as a signed level, clipped
    function automatic int draw_level();
        logic lsb;
        int   lvl;
        lsb      = osc_lfsr[0];
        osc_lfsr = osc_lfsr >> 1;
        if (lsb)
        begin
            osc_lfsr = osc_lfsr ^ LFSR_POLY;
        end
        lvl = int'($signed(osc_lfsr[15:0]));
        if (lvl < -PEAK)
        begin
            lvl = -PEAK;
        end
        return lvl;
    endfunction

    // sample for the current phase, then advance the phase by step * freq
    function automatic logic [SAMPLE_W-1:0] predict_sample(input logic [STEP_W-1:0] step);
        logic        first_half;
        logic [63:0] ramp;
        int          s;
        first_half = !osc_phase[31];
        s          = 0;
        case (osc_wave)
            WAVE_SQUARE:
            begin
                s = first_half ? -PEAK : PEAK;
            end
            WAVE_SINE:
            begin
                s = sine_at(osc_phase);
            end
            WAVE_SAW:
            begin
                ramp = (64'(osc_phase) * 64'd65534) >> 32;
                s    = int'(ramp) - PEAK;
            end
            WAVE_NOISE:
            begin
                s = draw_level();
            end
            WAVE_RSQUARE:
            begin
                // draw at the start of a cycle, flip sign at mid-cycle
                if (first_half)
                begin
                    if (osc_upper_half)
                    begin
                        osc_level = 16'(draw_level());
                    end
                    osc_upper_half = 1'b0;
                end
                else
                begin
                    if (!osc_upper_half)
                    begin
                        osc_level = -osc_level;
                    end
                    osc_upper_half = 1'b1;
                end
                s = int'(osc_level);
            end
            default:
            begin
                s = 0;
            end
        endcase
        osc_phase = osc_phase + 32'(step) * 32'(osc_freq);
        return 16'(s);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic flag_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Sample everything at the rising edge: inputs were driven at the
    // falling edge, so all values read here are settled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // compare the output word first; it can never belong to the
            // input word accepted at this same edge
            if (m_tvalid && m_tready)
            begin
                if (expected_samples.size() == 0)
                begin
                    flag_mismatch($sformatf("sample %0d with nothing expected",
                                            $signed(m_tdata)));
                end
                else
                begin
                    want_sample = expected_samples.pop_front();
                    if (m_tdata !== want_sample)
                    begin
                        flag_mismatch($sformatf("sample %0d, expected %0d",
                                                $signed(m_tdata), $signed(want_sample)));
                    end
                end
            end
            // mirror register writes
            if (cfg_we)
            begin
                if (cfg_addr == REG_WAVEFORM)
                begin
                    osc_wave = cfg_wdata[WAVE_W-1:0];
                end
                else if (cfg_addr == REG_FREQUENCY)
                begin
                    osc_freq = cfg_wdata[FREQ_W-1:0];
                end
            end
            // predict for the accepted time-step word; the predictor always
            // runs so its state advances, a typed value overrides it
            if (s_tvalid && s_tready)
            begin
                new_sample = predict_sample(s_tdata);
                expected_samples.push_back(step_typed ? step_typed_sample : new_sample);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // receiver back-pressure; stall_pct is updated by nonblocking writes
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Entered and left just after a falling edge. Idle a random number of
    // cycles, present the word, hold it until accepted.
    task automatic send_step(input logic [STEP_W-1:0] step, input logic typed,
                             input logic [SAMPLE_W-1:0] typed_sample);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= STEP_W'($urandom);
            @(negedge clk);
        end
        s_tvalid          <= 1'b1;
        s_tdata           <= step;
        step_typed        <= typed;
        step_typed_sample <= typed_sample;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Drain the block, then write both registers on consecutive cycles.
    task automatic write_config(input logic [15:0] wave_word, input logic [15:0] freq_word);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_WAVEFORM;
        cfg_wdata <= wave_word;
        @(negedge clk);
        cfg_addr  <= REG_FREQUENCY;
        cfg_wdata <= freq_word;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [31:0]       lookahead;
        logic              lsb;
        logic              found;
        int                draws;
        logic [STEP_W-1:0] step;
        logic [WAVE_W-1:0] wave;
        logic [15:0]       freq;

        // hold reset low, then release it on a falling edge
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // directed table, with both sides idling now and then
        send_idle_pct = SEND_IDLE[3];
        stall_pct    <= RECV_STALL[3];
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                write_config(directed_plan[i].word, directed_plan[i].freq);
            end
            else
            begin
                send_step(directed_plan[i].word, directed_plan[i].typed,
                          directed_plan[i].sample);
            end
        end

        // Drive noise words up to the most negative code if the LFSR lands
        // on it within a short window; it must come out clipped. Look ahead
        // on a copy of the state.
        send_idle_pct = SEND_IDLE[0];
        stall_pct    <= RECV_STALL[0];
        write_config(16'(WAVE_NOISE), 16'($urandom));
        lookahead = osc_lfsr;
        found     = 1'b0;
        draws     = 0;
        while (!found && draws < HUNT_LIMIT)
        begin
            lsb       = lookahead[0];
            lookahead = lookahead >> 1;
            if (lsb)
            begin
                lookahead = lookahead ^ LFSR_POLY;
            end
            draws++;
            found = (lookahead[15:0] == 16'h8000);
        end
        if (found)
        begin
            repeat (draws) send_step(STEP_W'($urandom), 1'b0, '0);
        end

        // random blocks: a fresh setting per block, four idling modes
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            send_idle_pct = SEND_IDLE[blk / 4];
            stall_pct    <= RECV_STALL[blk / 4];
            // favor random square: it needs many words to cross its halves
            wave = ($urandom_range(3) == 0) ? WAVE_W'(WAVE_RSQUARE)
                                            : WAVE_W'($urandom_range(7));
            case ($urandom_range(7))
                0:       freq = 16'h0000;
                1:       freq = 16'hFFFF;
                2:       freq = 16'h0001;
                default: freq = 16'($urandom);
            endcase
            write_config({13'($urandom), wave}, freq);
            for (int n = 0; n < BLOCK_WORDS; n++)
            begin
                step = ($urandom_range(3) == 0) ? STEP_W'($urandom_range(255))
                                                : STEP_W'($urandom);
                send_step(step, 1'b0, '0);
            end
        end

        // drain, then let the pipeline idle so that stray words can show
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);

        if (mismatch_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog: well beyond the slowest legal run, clipping hunt included
    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[sim.f]
src/lfo_pkg.sv
src/lfo_accum.sv
src/lfo_rand.sv
src/lfo_shape.sv
src/lfo_waveform_generator.sv
src/lfo_checker.sv
tb/sv/lfo_waveform_generator_tb.sv
